/* hw/rtl/lms_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lms_pkg: shared types and constants of the LED matrix row scanner
// Field widths, request and result codes, the scan state type, the default
// panel geometry and a helper that turns a count into an index width.
// ----------------------------------------------------------------------------
package lms_pkg;

    // Default panel geometry
    localparam int LEVEL_COUNT_DEF  = 4;
    localparam int ROW_COUNT_DEF    = 16;
    localparam int COLUMN_COUNT_DEF = 32;

    // Request and result field widths
    localparam int LEVEL_IN_W  = 2;
    localparam int ROW_IN_W    = 4;
    localparam int COLUMN_IN_W = 5;
    localparam int COLOR_W     = 6;
    localparam int ROW_ADDR_W  = 4;

    // Width used to compare write coordinates against the geometry
    localparam int CMP_W = 8;

    // Request type codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Result kind codes
    localparam logic KIND_SHIFT = 1'b0;
    localparam logic KIND_LATCH = 1'b1;

    // Scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_LATCH
    } t_scan_state;

    // Index width for a count of n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/lms_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lms_in_if / lms_out_if: request and result channels
// Valid/ready channels; a request or result moves at a rising edge where
// valid and ready are both high.
// ----------------------------------------------------------------------------
interface lms_in_if
    import lms_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [LEVEL_IN_W-1:0]  wr_level;
    logic [ROW_IN_W-1:0]    wr_row;
    logic [COLUMN_IN_W-1:0] wr_column;
    logic [COLOR_W-1:0]     wr_color;

    modport source (
        output valid, req_type, wr_level, wr_row, wr_column, wr_color,
        input  ready
    );
    modport sink (
        input  valid, req_type, wr_level, wr_row, wr_column, wr_color,
        output ready
    );
endinterface

interface lms_out_if
    import lms_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  out_kind;
    logic [COLOR_W-1:0]    shift_color;
    logic [ROW_ADDR_W-1:0] row_address;
    logic                  last;

    modport source (
        output valid, out_kind, shift_color, row_address, last,
        input  ready
    );
    modport sink (
        input  valid, out_kind, shift_color, row_address, last,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/lms_frame_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lms_frame_mem: frame store of the row scanner
// Single-port-write, single-port-read synchronous RAM with registered read
// data, plus the clearing sweep that zeroes every entry after reset.
// ----------------------------------------------------------------------------
module lms_frame_mem
    import lms_pkg::*;
#(
    parameter int ADDR_W = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [COLOR_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic [COLOR_W-1:0]     o_rd_data,
    output logic                   o_clr_busy
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [COLOR_W-1:0] r_mem [DEPTH];
    logic [COLOR_W-1:0] r_rd_data;
    logic               r_clr_busy;
    logic [ADDR_W-1:0]  r_clr_addr;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;

    // Clearing sweep: one entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Write port mux: sweep owns the port while it runs
    always_comb begin
        mem_we    = r_clr_busy | i_wr_en;
        mem_waddr = r_clr_busy ? r_clr_addr : i_wr_addr;
        mem_wdata = r_clr_busy ? '0 : i_wr_data;
    end

    // Storage array
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

`ifndef SYNTH
    // Requests never write while the sweep still owns the store
    a_no_wr_during_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_wr_en)
        else $error("frame store written during clearing sweep");
`endif

endmodule
`default_nettype wire

/* hw/rtl/lms_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lms_scan: scan sequencer of the row scanner
// Takes requests, stores writes, on a tick reads one column word per cycle
// unless o_res stalls, emits shift then latch results, steps row and level.
// ----------------------------------------------------------------------------
module lms_scan
    import lms_pkg::*;
#(
    parameter int LEVEL_COUNT  = LEVEL_COUNT_DEF,
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF,
    parameter int LVL_W        = idx_w(LEVEL_COUNT_DEF),
    parameter int ROW_W        = idx_w(ROW_COUNT_DEF),
    parameter int COL_W        = idx_w(COLUMN_COUNT_DEF),
    parameter int ADDR_W       = LVL_W + ROW_W + COL_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    lms_in_if.sink                  i_req,
    lms_out_if.source               o_res,
    output logic                    o_wr_en,
    output logic [ADDR_W-1:0]       o_wr_addr,
    output logic [COLOR_W-1:0]      o_wr_data,
    output logic                    o_rd_en,
    output logic [ADDR_W-1:0]       o_rd_addr,
    input  wire logic [COLOR_W-1:0] i_rd_data,
    input  wire logic               i_clr_busy
);

    t_scan_state r_state, n_state;
    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [LVL_W-1:0]      r_level, n_level;
    logic                  r_rd_pend, n_rd_pend;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_kind, n_out_kind;
    logic [COLOR_W-1:0]    r_out_color, n_out_color;
    logic [ROW_ADDR_W-1:0] r_out_row, n_out_row;
    logic                  r_out_last, n_out_last;

    logic             req_accept;
    logic             out_free;
    logic             load_mem;
    logic             can_issue;
    logic             wr_in_range;
    logic [CMP_W-1:0] wr_lvl_ext;
    logic [CMP_W-1:0] wr_row_ext;
    logic [CMP_W-1:0] wr_col_ext;

    // Request side handshake
    assign i_req.ready = (r_state == ST_IDLE) && !i_clr_busy;
    assign req_accept  = i_req.valid && i_req.ready;

    // Write decode with range check
    always_comb begin
        wr_lvl_ext  = CMP_W'(i_req.wr_level);
        wr_row_ext  = CMP_W'(i_req.wr_row);
        wr_col_ext  = CMP_W'(i_req.wr_column);
        wr_in_range = (wr_lvl_ext < CMP_W'(LEVEL_COUNT)) &&
                      (wr_row_ext < CMP_W'(ROW_COUNT)) &&
                      (wr_col_ext < CMP_W'(COLUMN_COUNT));
    end

    assign o_wr_addr = {LVL_W'(wr_lvl_ext), ROW_W'(wr_row_ext), COL_W'(wr_col_ext)};
    assign o_wr_data = i_req.wr_color;
    assign o_rd_addr = {r_level, r_row, r_col};

    // Next state, read issue and result register
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_level     = r_level;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_color = r_out_color;
        n_out_row   = r_out_row;
        n_out_last  = r_out_last;
        o_wr_en     = 1'b0;
        o_rd_en     = 1'b0;

        out_free = !r_out_valid || o_res.ready;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        // Read data waiting from the store moves into the result register
        load_mem = r_rd_pend && out_free;
        if (load_mem) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_SHIFT;
            n_out_color = i_rd_data;
            n_out_row   = '0;
            n_out_last  = 1'b0;
            n_rd_pend   = 1'b0;
        end
        can_issue = !r_rd_pend || load_mem;

        unique case (r_state)
            ST_IDLE: begin
                if (req_accept) begin
                    if (i_req.req_type == REQ_WRITE) begin
                        o_wr_en = wr_in_range;
                    end else begin
                        n_state = ST_SHIFT;
                        n_col   = '0;
                    end
                end
            end
            ST_SHIFT: begin
                if (can_issue) begin
                    o_rd_en   = 1'b1;
                    n_rd_pend = 1'b1;
                    if (r_col == COL_W'(COLUMN_COUNT - 1)) begin
                        n_state = ST_LATCH;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            ST_LATCH: begin
                if (!r_rd_pend && out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_LATCH;
                    n_out_color = '0;
                    n_out_row   = ROW_ADDR_W'(r_row);
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                    // Advance the scan position
                    if (r_row == ROW_W'(ROW_COUNT - 1)) begin
                        n_row = '0;
                        if (r_level == LVL_W'(LEVEL_COUNT - 1)) begin
                            n_level = '0;
                        end else begin
                            n_level = r_level + 1'b1;
                        end
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_level     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_level     <= n_level;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        r_out_kind  <= n_out_kind;
        r_out_color <= n_out_color;
        r_out_row   <= n_out_row;
        r_out_last  <= n_out_last;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_kind    = r_out_kind;
    assign o_res.shift_color = r_out_color;
    assign o_res.row_address = r_out_row;
    assign o_res.last        = r_out_last;

`ifndef SYNTH
    // A latch result always ends the run and carries no color
    a_latch_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_LATCH)) |-> (r_out_last && (r_out_color == '0)))
        else $error("latch result with bad fields");

    // A read is only outstanding while a tick is in progress
    a_pend_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ((r_state == ST_SHIFT) || (r_state == ST_LATCH)))
        else $error("read pending outside a tick");

    // An accepted tick starts the column run
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && (i_req.req_type == REQ_TICK)) |=> (r_state == ST_SHIFT))
        else $error("tick did not start the shift run");

    // Column counter stays within the panel width
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> ((CMP_W'(r_col)) < CMP_W'(COLUMN_COUNT)))
        else $error("column counter out of range");
`endif

endmodule
`default_nettype wire

/* hw/rtl/led_matrix_row_scanner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_row_scanner: refresh engine for a double-row-scanned LED panel
// Frame store of level x double row x column color words; a tick shifts out
// one row of one level and latches it, then the scan advances.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries requests. A write request (req_type = 1) stores wr_color at
//   (wr_level, wr_row, wr_column); out-of-range writes are dropped. It gives
//   no result. A tick request (req_type = 0) yields COLUMN_COUNT shift
//   results (one column word each) and then one latch result holding the
//   row address with last = 1.
//   o_res carries results. The first shift result comes from the store's
//   read data register through the result register; with o_res.ready held
//   high the results follow one per cycle, and the next request is taken
//   once the latch result is registered. The frame store has a single read
//   port with registered read data and is read one column word per cycle
//   while o_res is ready.
//   Reset: the scan position returns to row 0, level 0, and a clearing sweep
//   zeroes the 2**(level+row+column index bits) frame store entries (2048 by
//   default), one entry per cycle; i_req.ready stays low until it is done.
//   Stall: when o_res.ready is low the result register holds and the read
//   sequence pauses; nothing is dropped. The next request is taken while the
//   latch result still waits in the result register.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner
    import lms_pkg::*;
#(
    parameter int LEVEL_COUNT  = LEVEL_COUNT_DEF,
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lms_in_if.sink    i_req,
    lms_out_if.source o_res
);

    localparam int LVL_W  = idx_w(LEVEL_COUNT);
    localparam int ROW_W  = idx_w(ROW_COUNT);
    localparam int COL_W  = idx_w(COLUMN_COUNT);
    localparam int ADDR_W = LVL_W + ROW_W + COL_W;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COLOR_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [COLOR_W-1:0] rd_data;
    logic               clr_busy;

    // Scan sequencer
    lms_scan #(
        .LEVEL_COUNT  (LEVEL_COUNT),
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT),
        .LVL_W        (LVL_W),
        .ROW_W        (ROW_W),
        .COL_W        (COL_W),
        .ADDR_W       (ADDR_W)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_res      (o_res),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .i_clr_busy (clr_busy)
    );

    // Frame store
    lms_frame_mem #(
        .ADDR_W (ADDR_W)
    ) u_frame_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .o_clr_busy (clr_busy)
    );

endmodule
`default_nettype wire
